@@ hdl/i2a_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2a_pkg: shared types and constants for the integer to ASCII formatter
// Field widths, mode codes, ASCII constants, the load record passed to the
// character emitter and the nibble to character mapping.
// ----------------------------------------------------------------------------
package i2a_pkg;

  // Field widths.
  localparam int unsigned ModeW   = 2;
  localparam int unsigned ValueW  = 64;
  localparam int unsigned WordW   = 32;
  localparam int unsigned NibW    = 4;
  localparam int unsigned CharW   = 8;
  localparam int unsigned CountW  = 5;
  localparam int unsigned BcdDigs = 10;
  localparam int unsigned BcdW    = BcdDigs * NibW;

  // Format modes.
  localparam logic [ModeW-1:0] MODE_HEX_LO = 2'd0;
  localparam logic [ModeW-1:0] MODE_HEX_UP = 2'd1;
  localparam logic [ModeW-1:0] MODE_DEC    = 2'd2;
  localparam logic [ModeW-1:0] MODE_PTR    = 2'd3;

  // Digit counts for each mode.
  localparam logic [CountW-1:0] NDIG_HEX = 5'd8;
  localparam logic [CountW-1:0] NDIG_DEC = 5'd10;
  localparam logic [CountW-1:0] NDIG_PTR = 5'd16;
  localparam logic [CountW-1:0] PFX_LEN  = 5'd2;

  // ASCII codes.
  localparam logic [CharW-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CharW-1:0] CHAR_X    = 8'h78;
  localparam logic [CharW-1:0] CHAR_A_LO = 8'h61;
  localparam logic [CharW-1:0] CHAR_A_UP = 8'h41;

  // Work handed to the emitter: digits left aligned, most significant first.
  typedef struct packed {
    logic [ValueW-1:0] digits;
    logic [CountW-1:0] ndig;
    logic              pfx;
    logic              upper;
  } i2a_load_t;

  // Map one digit nibble to its ASCII character.
  function automatic logic [CharW-1:0] nib_char(input logic [NibW-1:0] nib,
                                                input logic upper);
    logic [CharW-1:0] ext;
    ext = {{(CharW-NibW){1'b0}}, nib};
    if (nib < 4'd10) begin
      return CHAR_ZERO + ext;
    end else if (upper) begin
      return CHAR_A_UP + ext - 8'd10;
    end else begin
      return CHAR_A_LO + ext - 8'd10;
    end
  endfunction

endpackage
`default_nettype wire

@@ hdl/i2a_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2a_in_if: input channel of the formatter
// Valid/ready channel carrying one mode and one value per beat.
// ----------------------------------------------------------------------------
interface i2a_in_if;
  logic                          valid;
  logic                          ready;
  logic [i2a_pkg::ModeW-1:0]     mode;
  logic [i2a_pkg::ValueW-1:0]    value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface
`default_nettype wire

@@ hdl/i2a_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2a_out_if: character channel of the formatter
// Valid/ready channel carrying one ASCII character per beat.
// ----------------------------------------------------------------------------
interface i2a_out_if;
  logic                          valid;
  logic                          ready;
  logic [i2a_pkg::CharW-1:0]     char_out;
  logic                          last;
  logic [i2a_pkg::CountW-1:0]    char_count;

  modport source (output valid, output char_out, output last, output char_count,
                  input ready);
  modport sink   (input valid, input char_out, input last, input char_count,
                  output ready);
endinterface
`default_nettype wire

@@ hdl/i2a_bcd.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2a_bcd: bit-serial binary to BCD converter
// Shift-and-add-three conversion of a 32-bit word, one input bit per cycle,
// giving ten BCD digits.
// ----------------------------------------------------------------------------
module i2a_bcd (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [i2a_pkg::WordW-1:0]   bin,
  output logic                             busy,
  output logic                             done,
  output logic [i2a_pkg::BcdW-1:0]         bcd
);

  localparam int unsigned CntW = $clog2(i2a_pkg::WordW);

  logic [i2a_pkg::WordW-1:0] bin_r, bin_nxt;
  logic [i2a_pkg::BcdW-1:0]  bcd_r, bcd_nxt;
  logic [i2a_pkg::BcdW-1:0]  adj;
  logic [CntW-1:0]           cnt_r, cnt_nxt;
  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;

  // Add three to every digit of five or more before the shift.
  always_comb begin
    for (int d = 0; d < i2a_pkg::BcdDigs; d++) begin
      if (bcd_r[d*i2a_pkg::NibW +: i2a_pkg::NibW] >= 4'd5) begin
        adj[d*i2a_pkg::NibW +: i2a_pkg::NibW] =
          bcd_r[d*i2a_pkg::NibW +: i2a_pkg::NibW] + 4'd3;
      end else begin
        adj[d*i2a_pkg::NibW +: i2a_pkg::NibW] =
          bcd_r[d*i2a_pkg::NibW +: i2a_pkg::NibW];
      end
    end
  end

  // Sequencing: load, then one shift per cycle until every bit is in.
  always_comb begin
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (busy_r) begin
      bcd_nxt = {adj[i2a_pkg::BcdW-2:0], bin_r[i2a_pkg::WordW-1]};
      bin_nxt = {bin_r[i2a_pkg::WordW-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (start) begin
      bin_nxt  = bin;
      bcd_nxt  = '0;
      cnt_nxt  = CntW'(i2a_pkg::WordW - 1);
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
    cnt_r <= cnt_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign bcd  = bcd_r;

endmodule
`default_nettype wire

@@ hdl/i2a_emit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2a_emit: character emitter
// Drops leading zero digits one nibble per cycle, then sends the optional
// "0x" prefix and the digits, one character per beat, through an output
// register.
// ----------------------------------------------------------------------------
module i2a_emit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               load,
  input  wire i2a_pkg::i2a_load_t ld,
  output logic                    busy,
  i2a_out_if.source               out_ch
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SKIP = 3'd1;
  localparam logic [2:0] ST_PFX0 = 3'd2;
  localparam logic [2:0] ST_PFX1 = 3'd3;
  localparam logic [2:0] ST_DIG  = 3'd4;

  localparam int unsigned TopLo = i2a_pkg::ValueW - i2a_pkg::NibW;

  logic [2:0]                   state_r, state_nxt;
  logic [i2a_pkg::ValueW-1:0]   digits_r, digits_nxt;
  logic [i2a_pkg::CountW-1:0]   left_r, left_nxt;
  logic [i2a_pkg::CountW-1:0]   total_r, total_nxt;
  logic                         pfx_r, pfx_nxt;
  logic                         upper_r, upper_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [i2a_pkg::CharW-1:0]    char_r, char_nxt;
  logic                         last_r, last_nxt;
  logic [i2a_pkg::CountW-1:0]   count_r, count_nxt;
  logic                         adv;
  logic [i2a_pkg::NibW-1:0]     top_nib;

  assign top_nib = digits_r[i2a_pkg::ValueW-1:TopLo];
  // The output register can take a new beat when empty or being drained.
  assign adv     = !out_valid_r || out_ch.ready;

  // Digit sequencing and output register loading.
  always_comb begin
    state_nxt     = state_r;
    digits_nxt    = digits_r;
    left_nxt      = left_r;
    total_nxt     = total_r;
    pfx_nxt       = pfx_r;
    upper_nxt     = upper_r;
    out_valid_nxt = out_valid_r;
    char_nxt      = char_r;
    last_nxt      = last_r;
    count_nxt     = count_r;
    if (adv) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (load) begin
          digits_nxt = ld.digits;
          left_nxt   = ld.ndig;
          pfx_nxt    = ld.pfx;
          upper_nxt  = ld.upper;
          state_nxt  = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (top_nib == '0 && left_r > 5'd1) begin
          digits_nxt = {digits_r[TopLo-1:0], {i2a_pkg::NibW{1'b0}}};
          left_nxt   = left_r - 1'b1;
        end else begin
          total_nxt = left_r + (pfx_r ? i2a_pkg::PFX_LEN : '0);
          state_nxt = pfx_r ? ST_PFX0 : ST_DIG;
        end
      end
      ST_PFX0: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          char_nxt      = i2a_pkg::CHAR_ZERO;
          last_nxt      = 1'b0;
          count_nxt     = '0;
          state_nxt     = ST_PFX1;
        end
      end
      ST_PFX1: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          char_nxt      = i2a_pkg::CHAR_X;
          last_nxt      = 1'b0;
          count_nxt     = '0;
          state_nxt     = ST_DIG;
        end
      end
      ST_DIG: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          char_nxt      = i2a_pkg::nib_char(top_nib, upper_r);
          last_nxt      = (left_r == 5'd1);
          count_nxt     = (left_r == 5'd1) ? total_r : '0;
          digits_nxt    = {digits_r[TopLo-1:0], {i2a_pkg::NibW{1'b0}}};
          left_nxt      = left_r - 1'b1;
          if (left_r == 5'd1) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    digits_r <= digits_nxt;
    left_r   <= left_nxt;
    total_r  <= total_nxt;
    pfx_r    <= pfx_nxt;
    upper_r  <= upper_nxt;
    char_r   <= char_nxt;
    last_r   <= last_nxt;
    count_r  <= count_nxt;
  end

  assign busy              = (state_r != ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.char_out   = char_r;
  assign out_ch.last       = last_r;
  assign out_ch.char_count = count_r;

endmodule
`default_nettype wire

@@ hdl/integer_to_ascii_formatter.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter: number to ASCII text converter
// Formats one value as lower or upper case hex, unsigned decimal or a
// "0x" pointer, most significant character first without leading zeros.
// ----------------------------------------------------------------------------
//  Channel  | Dir | Beat payload                  | Handshake
//  in_ch    | in  | mode[1:0], value[63:0]        | valid/ready
//  out_ch   | out | char_out[7:0], last, char_count[4:0] | valid/ready
//
// One value is worked on at a time. Hex and pointer values are accepted, then
// their leading zero digits are dropped, the text is started and its
// characters are sent one per beat. Decimal values first pass through the
// bit-serial BCD converter and are then handed over to the emitter. Reset
// (synchronous, rst_n low) empties the output register and idles both units.
// A stalled out_ch holds the current character and pauses emission.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter (
  input  wire logic  clk,
  input  wire logic  rst_n,
  i2a_in_if.sink     in_ch,
  i2a_out_if.source  out_ch
);

  logic                       bcd_busy;
  logic                       bcd_done;
  logic [i2a_pkg::BcdW-1:0]   bcd;
  logic                       emit_busy;
  logic                       accept;
  logic                       bcd_start;
  logic                       emit_load;
  i2a_pkg::i2a_load_t         ld;

  // Take a new value only when both units are free.
  assign in_ch.ready = !bcd_busy && !bcd_done && !emit_busy;
  assign accept      = in_ch.valid && in_ch.ready;

  // Route the beat: decimal goes through the converter, the rest straight on.
  always_comb begin
    bcd_start = 1'b0;
    emit_load = 1'b0;
    ld.digits = {in_ch.value[i2a_pkg::WordW-1:0], {i2a_pkg::WordW{1'b0}}};
    ld.ndig   = i2a_pkg::NDIG_HEX;
    ld.pfx    = 1'b0;
    ld.upper  = 1'b0;
    if (bcd_done) begin
      emit_load = 1'b1;
      ld.digits = {bcd, {(i2a_pkg::ValueW - i2a_pkg::BcdW){1'b0}}};
      ld.ndig   = i2a_pkg::NDIG_DEC;
    end else if (accept) begin
      unique case (in_ch.mode)
        i2a_pkg::MODE_HEX_LO: begin
          emit_load = 1'b1;
        end
        i2a_pkg::MODE_HEX_UP: begin
          emit_load = 1'b1;
          ld.upper  = 1'b1;
        end
        i2a_pkg::MODE_DEC: begin
          bcd_start = 1'b1;
        end
        i2a_pkg::MODE_PTR: begin
          emit_load = 1'b1;
          ld.digits = in_ch.value;
          ld.ndig   = i2a_pkg::NDIG_PTR;
          ld.pfx    = 1'b1;
        end
        default: begin
          emit_load = 1'b0;
        end
      endcase
    end
  end

  i2a_bcd u_bcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (bcd_start),
    .bin   (in_ch.value[i2a_pkg::WordW-1:0]),
    .busy  (bcd_busy),
    .done  (bcd_done),
    .bcd   (bcd)
  );

  i2a_emit u_emit (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (emit_load),
    .ld     (ld),
    .busy   (emit_busy),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire
